[hw/rtl/hgs_pkg.sv]
package hgs_pkg;

  // fixed-point format of every 48-bit value
  localparam int FRACTION_BITS = 16;
  localparam int DATA_W        = 48;
  localparam int PRES_W        = DATA_W - 1;
  localparam int GAS_W         = 32;

  // accumulator holds gas * |tv| * |dp|
  localparam int M_W   = GAS_W + DATA_W;
  localparam int ACC_W = GAS_W + 2 * DATA_W;
  localparam int CNT_W = $clog2(DATA_W);

  localparam logic [GAS_W-1:0]  GAS_RESET = GAS_W'(18811453);
  localparam logic [DATA_W-1:0] SAT_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [PRES_W-1:0]        level_pressure;
    logic signed [DATA_W-1:0] virtual_temp;
    logic signed [DATA_W-1:0] layer_thickness;
    logic signed [DATA_W-1:0] surface_geopot;
    logic                     column_start;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] geopotential;
    logic                     range_error;
  } out_item_t;

  // finished result offered by the sequencer
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

[hw/rtl/hgs_addsub.sv]
module hgs_addsub (
  input  logic [hgs_pkg::ACC_W-1:0] a,
  input  logic [hgs_pkg::ACC_W-1:0] b,
  input  logic                      sub,
  output logic [hgs_pkg::ACC_W-1:0] sum,
  output logic                      carry
);
  import hgs_pkg::*;

  logic [ACC_W-1:0] b_eff;

  // shared wide adder, carry out set means a >= b when subtracting
  assign b_eff = sub ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + {{ACC_W{1'b0}}, sub};

endmodule

[hw/rtl/hgs_seq.sv]
module hgs_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [hgs_pkg::GAS_W-1:0] gas,
  input  logic                      in_valid,
  input  hgs_pkg::in_item_t         in_item,
  output logic                      in_stall,
  output hgs_pkg::res_t             res,
  input  logic                      res_ready
);
  import hgs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL1 = 7'b0000010,
    S_MUL2 = 7'b0000100,
    S_CMP  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_WSAT = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  localparam logic [CNT_W-1:0] GAS_LAST  = CNT_W'(GAS_W - 1);
  localparam logic [CNT_W-1:0] DATA_LAST = CNT_W'(DATA_W - 1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [ACC_W-1:0]   acc_r;
  logic [M_W-1:0]     m_r;
  logic [DATA_W-1:0]  mplier_r;
  logic [DATA_W-1:0]  dpm_r;
  logic [DATA_W-1:0]  rem_r;
  logic [DATA_W-1:0]  q_r;
  logic [PRES_W-1:0]  pres_r;
  logic [DATA_W-1:0]  phis_r;
  logic [DATA_W-1:0]  w_r;
  logic [DATA_W-1:0]  sum_r;
  logic               start_r, neg_r, zero_r, big_r, flag_r;

  logic               accept;
  logic [DATA_W-1:0]  tv_mag, dp_mag, rem2;
  logic [ACC_W-1:0]   op_a, op_b, add_sum;
  logic               op_sub, add_carry;
  logic [DATA_W-1:0]  w_nxt;
  logic               wflag_nxt;
  logic [DATA_W-1:0]  sum_eff, half;
  logic [DATA_W+1:0]  phi_x;
  logic [DATA_W:0]    nsum_x;
  logic               phi_ovf, sum_ovf;
  logic [DATA_W-1:0]  phi_sat, nsum_sat;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  // magnitudes of the signed factors
  assign tv_mag = in_item.virtual_temp[DATA_W-1] ?
                  (~in_item.virtual_temp + 1'b1) : in_item.virtual_temp;
  assign dp_mag = in_item.layer_thickness[DATA_W-1] ?
                  (~in_item.layer_thickness + 1'b1) : in_item.layer_thickness;

  // partial remainder with the next numerator bit shifted in
  assign rem2 = {rem_r[DATA_W-2:0], acc_r[FRACTION_BITS+DATA_W-1]};

  // operand select for the shared adder
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    unique case (state_r)
      S_MUL1, S_MUL2: begin
        op_a = acc_r << 1;
        op_b = mplier_r[DATA_W-1] ? ACC_W'(m_r) : '0;
      end
      S_CMP: begin
        op_a   = ACC_W'(acc_r[ACC_W-1:FRACTION_BITS+DATA_W]);
        op_b   = ACC_W'(pres_r);
        op_sub = 1'b1;
      end
      S_DIV: begin
        op_a   = ACC_W'(rem2);
        op_b   = ACC_W'(pres_r);
        op_sub = 1'b1;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  hgs_addsub u_addsub (
    .a     (op_a),
    .b     (op_b),
    .sub   (op_sub),
    .sum   (add_sum),
    .carry (add_carry)
  );

  // signed increment with saturation
  always_comb begin
    w_nxt     = q_r;
    wflag_nxt = 1'b0;
    if (big_r) begin
      w_nxt     = (neg_r && !zero_r) ? SAT_MIN : SAT_MAX;
      wflag_nxt = 1'b1;
    end else if (!neg_r) begin
      if (q_r[DATA_W-1]) begin
        w_nxt     = SAT_MAX;
        wflag_nxt = 1'b1;
      end
    end else if (q_r[DATA_W-1] && (|q_r[DATA_W-2:0])) begin
      w_nxt     = SAT_MIN;
      wflag_nxt = 1'b1;
    end else begin
      w_nxt = ~q_r + 1'b1;
    end
  end

  // geopotential and new running sum
  assign sum_eff  = start_r ? '0 : sum_r;
  assign half     = {w_r[DATA_W-1], w_r[DATA_W-1:1]};
  assign phi_x    = {{2{phis_r[DATA_W-1]}}, phis_r} + {{2{sum_eff[DATA_W-1]}}, sum_eff}
                  + {{2{half[DATA_W-1]}}, half};
  assign nsum_x   = {sum_eff[DATA_W-1], sum_eff} + {w_r[DATA_W-1], w_r};
  assign phi_ovf  = (phi_x[DATA_W+1] != phi_x[DATA_W-1]) || (phi_x[DATA_W] != phi_x[DATA_W-1]);
  assign sum_ovf  = (nsum_x[DATA_W] != nsum_x[DATA_W-1]);
  assign phi_sat  = phi_ovf ? (phi_x[DATA_W+1] ? SAT_MIN : SAT_MAX) : phi_x[DATA_W-1:0];
  assign nsum_sat = sum_ovf ? (nsum_x[DATA_W] ? SAT_MIN : SAT_MAX) : nsum_x[DATA_W-1:0];

  assign res.valid                  = (state_r == S_FIN);
  assign res.item.geopotential      = phi_sat;
  assign res.item.range_error       = flag_r || phi_ovf || sum_ovf;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MUL1;
      S_MUL1: if (cnt_r == GAS_LAST) state_nxt = S_MUL2;
      S_MUL2: if (cnt_r == DATA_LAST) state_nxt = S_CMP;
      S_CMP:  state_nxt = add_carry ? S_WSAT : S_DIV;
      S_DIV:  if (cnt_r == DATA_LAST) state_nxt = S_WSAT;
      S_WSAT: state_nxt = S_FIN;
      S_FIN:  if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept || (state_r == S_CMP) || (state_nxt != state_r)) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
      if ((state_r == S_FIN) && res_ready) begin
        sum_r <= nsum_sat;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pres_r   <= in_item.level_pressure;
          phis_r   <= in_item.surface_geopot;
          start_r  <= in_item.column_start;
          neg_r    <= in_item.virtual_temp[DATA_W-1] ^ in_item.layer_thickness[DATA_W-1];
          dpm_r    <= dp_mag;
          m_r      <= M_W'(tv_mag);
          mplier_r <= {gas, {(DATA_W-GAS_W){1'b0}}};
          acc_r    <= '0;
        end
      end
      S_MUL1: begin
        mplier_r <= mplier_r << 1;
        if (cnt_r == GAS_LAST) begin
          m_r      <= add_sum[M_W-1:0];
          acc_r    <= '0;
          mplier_r <= dpm_r;
        end else begin
          acc_r <= add_sum;
        end
      end
      S_MUL2: begin
        mplier_r <= mplier_r << 1;
        acc_r    <= add_sum;
      end
      S_CMP: begin
        zero_r <= (acc_r == '0);
        big_r  <= add_carry;
        rem_r  <= acc_r[FRACTION_BITS+DATA_W +: DATA_W];
        q_r    <= '0;
      end
      S_DIV: begin
        acc_r <= acc_r << 1;
        if (add_carry) begin
          rem_r <= add_sum[DATA_W-1:0];
          q_r   <= {q_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_r <= rem2;
          q_r   <= {q_r[DATA_W-2:0], 1'b0};
        end
      end
      S_WSAT: begin
        w_r    <= w_nxt;
        flag_r <= wflag_nxt;
      end
      S_FIN: begin
        w_r <= w_r;
      end
      default: begin
        w_r <= w_r;
      end
    endcase
  end

endmodule

[hw/rtl/hydrostatic_geopotential_scan.sv]
// channel | handshake             | payload
// --------+-----------------------+---------------------------------
// in      | in_valid / in_stall   | in_data   (level fields)
// out     | out_valid / out_stall | out_data  (geopotential, flag)
// cfg     | cfg_valid / cfg_ready | cfg_data  (gas constant)
//
// Each item runs through one shared 128-bit adder: the accept step, 32 + 48
// shift-add steps, one range compare, 48 restoring divide steps and the finishing
// states S_WSAT and S_FIN; zero pressure or an oversize quotient skips the divide.
// Reset is synchronous; it clears the running sum and restores the gas constant.
// A result waits in the output register under out_stall while the next item
// is taken; the sequencer holds its result only if that register is still full.
module hydrostatic_geopotential_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  hgs_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output hgs_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [hgs_pkg::GAS_W-1:0] cfg_data
);
  import hgs_pkg::*;

  logic [GAS_W-1:0] gas_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  res_t             res;
  logic             res_ready;

  // gas constant register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gas_r <= GAS_RESET;
    end else if (cfg_valid) begin
      gas_r <= cfg_data;
    end
  end

  hgs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .gas       (gas_r),
    .in_valid  (in_valid),
    .in_item   (in_data),
    .in_stall  (in_stall),
    .res       (res),
    .res_ready (res_ready)
  );

  // output register
  assign res_ready = !out_valid_r || !out_stall;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_data_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/sv/tb_hydrostatic_geopotential_scan.sv]
module tb_hydrostatic_geopotential_scan;
  import hgs_pkg::*;

  localparam int     RUN_LIMIT_CYCLES = 1_000_000;
  localparam longint GEO_MAX          = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint GEO_MIN          = -(longint'(1) <<< (DATA_W - 1));
  localparam logic [127:0] NEG_LIMIT  = 128'(1) << (DATA_W - 1);
  localparam logic [127:0] POS_LIMIT  = NEG_LIMIT - 1;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [GAS_W-1:0] cfg_data  = '0;

  // predictor state and handshake pacing
  logic [GAS_W-1:0] gas_const      = GAS_RESET;
  longint           running_sum    = 0;
  out_item_t        pending_geopot[$];
  int               mismatch_count = 0;
  int               send_idle_pct  = 11;
  int               recv_stall_pct = 56;

  hydrostatic_geopotential_scan dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial forever #10 clk = ~clk;

  initial begin
    #(RUN_LIMIT_CYCLES * 20);
    $display("tb_hydrostatic_geopotential_scan: errors");
    $finish;
  end

  // saturate to the 48-bit signed range and note the hit
  function automatic longint clamp_geo(input longint x, inout logic hit);
    if (x > GEO_MAX) begin
      hit = 1'b1;
      return GEO_MAX;
    end
    if (x < GEO_MIN) begin
      hit = 1'b1;
      return GEO_MIN;
    end
    return x;
  endfunction

  // expected geopotential of one level, advances the running sum
  function automatic out_item_t predict_level(input in_item_t lvl);
    logic [DATA_W-1:0] mag_tv, mag_dp;
    logic [127:0]      prod, quot;
    logic              neg, hit;
    longint            incr, phi;
    out_item_t         res;
    hit = 1'b0;
    if (lvl.column_start) running_sum = 0;
    mag_tv = lvl.virtual_temp;
    if (mag_tv[DATA_W-1]) mag_tv = -mag_tv;
    mag_dp = lvl.layer_thickness;
    if (mag_dp[DATA_W-1]) mag_dp = -mag_dp;
    // exact magnitude product, sign applied after the divide
    prod = 128'(gas_const);
    prod = prod * 128'(mag_tv);
    prod = prod * 128'(mag_dp);
    neg = (lvl.virtual_temp[DATA_W-1] ^ lvl.layer_thickness[DATA_W-1]) && (prod != '0);
    if (lvl.level_pressure == '0) begin
      hit  = 1'b1;
      incr = neg ? GEO_MIN : GEO_MAX;
    end else begin
      quot = (prod >> FRACTION_BITS) / 128'(lvl.level_pressure);
      if (neg) begin
        if (quot > NEG_LIMIT) begin
          hit  = 1'b1;
          incr = GEO_MIN;
        end else begin
          incr = -longint'(quot[63:0]);
        end
      end else if (quot > POS_LIMIT) begin
        hit  = 1'b1;
        incr = GEO_MAX;
      end else begin
        incr = longint'(quot[63:0]);
      end
    end
    // half increment rounds toward minus infinity
    phi = clamp_geo(longint'($signed(lvl.surface_geopot)) + running_sum + (incr >>> 1), hit);
    running_sum = clamp_geo(running_sum + incr, hit);
    res.geopotential = phi[DATA_W-1:0];
    res.range_error  = hit;
    return res;
  endfunction

  function automatic in_item_t make_level(input logic [DATA_W-1:0] p,
                                          input logic [DATA_W-1:0] tv, dp, phis,
                                          input logic start);
    in_item_t lvl;
    lvl.level_pressure  = p[PRES_W-1:0];
    lvl.virtual_temp    = tv;
    lvl.layer_thickness = dp;
    lvl.surface_geopot  = phis;
    lvl.column_start    = start;
    return lvl;
  endfunction

  // whole number with a random fraction
  function automatic logic [DATA_W-1:0] fixed_of(input int whole);
    return (DATA_W'(whole) << FRACTION_BITS) | DATA_W'($urandom_range(0, (1 << FRACTION_BITS) - 1));
  endfunction

  function automatic logic [DATA_W-1:0] rand_span(input int bits);
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    r = r >> (64 - bits);
    return r[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] signed_span();
    logic [DATA_W-1:0] r;
    r = rand_span($urandom_range(1, DATA_W));
    if ($urandom_range(1)) r = -r;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch: %s", what);
  endtask

  // offer one item, record its prediction once it is taken
  task automatic send_level(input in_item_t lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_geopot.push_back(predict_level(lvl));
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_geopot.size() != 0) @(posedge clk);
  endtask

  task automatic write_gas_constant(input logic [GAS_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    gas_const = value;
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin : check_result
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_geopot.size() == 0) begin
        report_mismatch($sformatf("unexpected item %h", out_data));
      end else begin
        want = pending_geopot.pop_front();
        if (out_data.geopotential !== want.geopotential)
          report_mismatch($sformatf("geopotential got %h want %h",
                                    out_data.geopotential, want.geopotential));
        if (out_data.range_error !== want.range_error)
          report_mismatch($sformatf("range_error got %b want %b (geopotential %h)",
                                    out_data.range_error, want.range_error,
                                    want.geopotential));
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // columns of mostly physical levels, some scaled and some noise
  task automatic send_columns(input int n_items);
    int                sent, depth, kind, p_whole, thick, i;
    in_item_t          lvl;
    logic [DATA_W-1:0] base_geo;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        // physical column, pressure falls level by level
        depth    = $urandom_range(1, 40);
        p_whole  = $urandom_range(60000, 105000);
        base_geo = fixed_of(int'($urandom_range(0, 60000)) - 2000);
        for (i = 0; i < depth && sent < n_items; i++) begin
          thick = $urandom_range(50, 4000);
          lvl = make_level(fixed_of(p_whole), fixed_of($urandom_range(180, 330)),
                           fixed_of(thick), base_geo, i == 0);
          p_whole = (p_whole > thick + 10) ? p_whole - thick : 10;
          send_level(lvl);
          sent++;
        end
      end else if (kind < 85) begin
        // fields of random width and sign
        depth    = $urandom_range(1, 12);
        base_geo = signed_span();
        for (i = 0; i < depth && sent < n_items; i++) begin
          lvl = make_level(rand_span($urandom_range(1, PRES_W)), signed_span(),
                           signed_span(), base_geo, i == 0);
          send_level(lvl);
          sent++;
        end
      end else begin
        // raw noise, sometimes with zero pressure
        lvl = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        if ($urandom_range(7) == 0) lvl.level_pressure = '0;
        send_level(lvl);
        sent++;
      end
    end
  endtask

  // reset gas constant, sum chaining, cleared and missing column starts
  task automatic test_column_basics();
    send_level(make_level(fixed_of(100000), fixed_of(300), fixed_of(1500), fixed_of(500), 1'b1));
    send_level(make_level(fixed_of(98000), fixed_of(295), fixed_of(1500), fixed_of(500), 1'b0));
    send_level(make_level(fixed_of(96000), fixed_of(-290), fixed_of(1200), fixed_of(500), 1'b0));
    send_level(make_level(DATA_W'(1), '0, '0, '0, 1'b1));
    send_level(make_level(fixed_of(90000), fixed_of(250), fixed_of(-800), fixed_of(-40), 1'b0));
    send_level(make_level(fixed_of(85000), fixed_of(260), fixed_of(700), fixed_of(20), 1'b1));
    wait_results_drained();
  endtask

  // zero pressure, increment and sum overflow, field extremes
  task automatic test_saturation();
    send_level(make_level(DATA_W'(1), SAT_MAX, SAT_MAX, '0, 1'b1));
    send_level(make_level(DATA_W'(1), SAT_MIN, SAT_MAX, '0, 1'b1));
    send_level(make_level('0, fixed_of(300), fixed_of(1000), fixed_of(100), 1'b1));
    send_level(make_level('0, fixed_of(-300), fixed_of(1000), '0, 1'b1));
    send_level(make_level('0, '0, SAT_MIN, '0, 1'b1));
    send_level(make_level(fixed_of(50000), fixed_of(300), fixed_of(2000), SAT_MAX, 1'b1));
    send_level(make_level(fixed_of(50000), fixed_of(-300), fixed_of(2000), SAT_MIN, 1'b1));
    send_level(make_level(DATA_W'(1), fixed_of(300), fixed_of(1000), '0, 1'b1));
    send_level(make_level(DATA_W'(1), fixed_of(300), fixed_of(1000), '0, 1'b0));
    send_level(make_level(SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN, 1'b1));
    wait_results_drained();
  endtask

  // smallest and largest gas constant
  task automatic test_gas_extremes();
    write_gas_constant('0);
    send_level(make_level(fixed_of(100000), fixed_of(300), fixed_of(1500), fixed_of(500), 1'b1));
    send_level(make_level('0, fixed_of(300), fixed_of(-1000), '0, 1'b0));
    wait_results_drained();
    write_gas_constant('1);
    send_level(make_level(fixed_of(100000), fixed_of(300), fixed_of(1500), '0, 1'b1));
    send_level(make_level(fixed_of(90000), SAT_MIN, fixed_of(1500), '0, 1'b0));
    send_level(make_level(DATA_W'(1), fixed_of(2), fixed_of(3), '0, 1'b0));
    wait_results_drained();
  endtask

  task automatic test_random_columns(input int n_items, input int send_pct,
                                     input int recv_pct, input logic [GAS_W-1:0] gas);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    write_gas_constant(gas);
    send_columns(n_items);
    wait_results_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_column_basics();
    test_saturation();
    test_gas_extremes();
    test_random_columns(480, 11, 56, $urandom());
    test_random_columns(480, 56, 11, GAS_W'(1) << FRACTION_BITS);
    test_random_columns(490, 0, 0, GAS_RESET);
    // catch any stray item after the last expected one
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_hydrostatic_geopotential_scan: clean");
    end else begin
      $display("tb_hydrostatic_geopotential_scan: errors");
    end
    $finish;
  end

endmodule
